>>> design/jittered_grid_sample_generator_unit_assert.svh
// assertion macros for the jittered grid sample generator
// used by the top level only, no other dependencies
`ifndef JITTERED_GRID_SAMPLE_GENERATOR_UNIT_ASSERT_SVH
`define JITTERED_GRID_SAMPLE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define JGSG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jgsg same-cycle check failed");

// next-cycle implication
`define JGSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jgsg next-cycle check failed");

`endif

>>> design/jgsg_pkg.sv
// types and constants shared by the jittered grid sample generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jgsg_pkg;

  localparam int FRAC_W      = 16;   // fraction bits of inputs and samples
  localparam int COUNT_W     = 13;   // requested and effective count
  localparam int INDEX_W     = 12;   // sample index within a pass
  localparam int DIM_W       = 7;    // grid columns, rows and their counters
  localparam int SQRT_STEP_W = 3;    // bit position of the root search
  localparam int DIV_STEP_W  = 4;    // quotient bit counter
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION_MODE  = 2'd1;

  typedef struct packed {
    logic [FRAC_W-1:0] rand_u;
    logic [FRAC_W-1:0] rand_v;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  sample_u;
    logic [FRAC_W-1:0]  sample_v;
    logic [INDEX_W-1:0] sample_index;
    logic [COUNT_W-1:0] effective_count;
    logic               pass_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                   wr_count;
    logic                   wr_mode;
    logic                   grid_start;
    logic                   sqrt_step;
    logic [SQRT_STEP_W-1:0] sqrt_bit;
    logic                   grid_set;
    logic                   eff_set;
    logic                   div_load;
    logic                   div_step;
    logic                   out_load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> design/jgsg_div.sv
// radix-2 restoring divider lane, one quotient bit per step
// numerator is pos * 2^16 + frac with pos below the divisor; uses jgsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module jgsg_div (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic                          step,
  input  wire logic [jgsg_pkg::INDEX_W-1:0]  pos,
  input  wire logic [jgsg_pkg::FRAC_W-1:0]   frac,
  input  wire logic [jgsg_pkg::COUNT_W-1:0]  divisor,
  output logic      [jgsg_pkg::FRAC_W-1:0]   quot
);

  logic [jgsg_pkg::COUNT_W-1:0] rem;
  logic [jgsg_pkg::COUNT_W-1:0] dvs;
  logic [jgsg_pkg::FRAC_W-1:0]  shq;   // low numerator bits shift out, quotient bits shift in
  logic [jgsg_pkg::COUNT_W:0]   rem_sh;
  logic                         fits;

  always_comb begin
    rem_sh = {rem, shq[jgsg_pkg::FRAC_W-1]};
    fits   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= {1'b0, pos};
      dvs <= divisor;
      shq <= frac;
    end else if (step) begin
      rem <= fits ? jgsg_pkg::COUNT_W'(rem_sh - {1'b0, dvs})
                  : jgsg_pkg::COUNT_W'(rem_sh);
      shq <= {shq[jgsg_pkg::FRAC_W-2:0], fits};
    end
  end

  assign quot = shq;

endmodule

`default_nettype wire

>>> design/jgsg_ctrl.sv
// sequencer: config decode, grid root search, divide steps, result hand-off
// drives the datapath through jgsg_pkg::ctrl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module jgsg_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             rand_valid,
  output logic                                  rand_stall,
  output logic                                  sample_valid,
  input  wire logic                             sample_stall,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [jgsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  output jgsg_pkg::ctrl_cmd_t                   cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_GRID,
    ST_EFF,
    ST_DIV,
    ST_WRITE
  } state_t;

  state_t state;
  logic [jgsg_pkg::DIV_STEP_W-1:0] step_cnt;
  logic cfg_wr;
  logic cfg_hit;
  logic take;

  always_comb begin
    cfg_ready  = (state == ST_IDLE) || (state == ST_SQRT);
    cfg_wr     = cfg_valid && cfg_ready;
    cfg_hit    = cfg_wr && ((cfg_index == jgsg_pkg::REG_REQUESTED_COUNT) ||
                            (cfg_index == jgsg_pkg::REG_DIMENSION_MODE));
    // a pending config write keeps the input side stalled
    rand_stall = (state != ST_IDLE) || cfg_valid;
    take       = rand_valid && !rand_stall;

    cmd.wr_count   = cfg_wr && (cfg_index == jgsg_pkg::REG_REQUESTED_COUNT);
    cmd.wr_mode    = cfg_wr && (cfg_index == jgsg_pkg::REG_DIMENSION_MODE);
    cmd.grid_start = cfg_hit;
    cmd.sqrt_step  = (state == ST_SQRT) && !cfg_hit;
    cmd.sqrt_bit   = step_cnt[jgsg_pkg::SQRT_STEP_W-1:0];
    cmd.grid_set   = (state == ST_GRID);
    cmd.eff_set    = (state == ST_EFF);
    cmd.div_load   = take;
    cmd.div_step   = (state == ST_DIV);
    cmd.out_load   = (state == ST_WRITE) && (!sample_valid || !sample_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_cnt     <= '0;
      sample_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        sample_valid <= 1'b1;
      end else if (!sample_stall) begin
        sample_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cfg_hit) begin
            state    <= ST_SQRT;
            step_cnt <= jgsg_pkg::DIV_STEP_W'(jgsg_pkg::DIM_W - 1);
          end else if (take) begin
            state    <= ST_DIV;
            step_cnt <= jgsg_pkg::DIV_STEP_W'(jgsg_pkg::FRAC_W - 1);
          end
        end
        ST_SQRT: begin
          if (cfg_hit) begin
            step_cnt <= jgsg_pkg::DIV_STEP_W'(jgsg_pkg::DIM_W - 1);
          end else if (step_cnt == '0) begin
            state <= ST_GRID;
          end else begin
            step_cnt <= step_cnt - 1'b1;
          end
        end
        ST_GRID: begin
          state <= ST_EFF;
        end
        ST_EFF: begin
          state <= ST_IDLE;
        end
        ST_DIV: begin
          if (step_cnt == '0) begin
            state <= ST_WRITE;
          end else begin
            step_cnt <= step_cnt - 1'b1;
          end
        end
        ST_WRITE: begin
          if (cmd.out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/jgsg_datapath.sv
// datapath: config registers, integer root and grid shape, stratum counters,
// two divider lanes and the result register; uses jgsg_pkg and jgsg_div
`timescale 1ns / 1ps
`default_nettype none

module jgsg_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire jgsg_pkg::ctrl_cmd_t             cmd,
  input  wire logic [jgsg_pkg::COUNT_W-1:0]    cfg_data,
  input  wire jgsg_pkg::in_item_t              rand_data,
  output jgsg_pkg::out_item_t                  sample_data
);

  localparam int DW = jgsg_pkg::DIM_W;
  localparam int CW = jgsg_pkg::COUNT_W;
  localparam int IW = jgsg_pkg::INDEX_W;

  logic [CW-1:0]   n_clamped;
  logic            mode;
  logic [DW-1:0]   root;
  logic [DW-1:0]   cols;
  logic [DW-1:0]   rows;
  logic [CW-1:0]   eff;
  logic [DW-1:0]   col_cnt;
  logic [DW-1:0]   row_cnt;
  logic [IW-1:0]   idx_cnt;

  logic [CW-1:0]   n_next;
  logic [DW-1:0]   trial;
  logic [2*DW-1:0] trial_sq;
  logic [2*DW-1:0] root_sq;
  logic [2*DW-1:0] grid_prod;
  logic            col_end;
  logic            last;

  logic [IW-1:0]   pos_u;
  logic [CW-1:0]   dvs_u;
  logic [jgsg_pkg::FRAC_W-1:0] quot_u;
  logic [jgsg_pkg::FRAC_W-1:0] quot_v;

  always_comb begin
    // zero counts as one, large counts saturate
    if (cfg_data == '0) begin
      n_next = CW'(1);
    end else if (cfg_data > jgsg_pkg::MAX_SAMPLES) begin
      n_next = jgsg_pkg::MAX_SAMPLES;
    end else begin
      n_next = cfg_data;
    end

    trial     = root | (DW'(1) << cmd.sqrt_bit);
    trial_sq  = trial * trial;
    root_sq   = root * root;
    grid_prod = cols * rows;

    col_end = (col_cnt == DW'(cols - 1'b1));
    last    = ({1'b0, idx_cnt} == CW'(eff - 1'b1));

    pos_u = mode ? idx_cnt : IW'(col_cnt);
    dvs_u = mode ? n_clamped : CW'(cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_clamped <= CW'(1);
      mode      <= 1'b0;
      root      <= '0;
      cols      <= DW'(1);
      rows      <= DW'(1);
      eff       <= CW'(1);
      col_cnt   <= '0;
      row_cnt   <= '0;
      idx_cnt   <= '0;
    end else begin
      if (cmd.wr_count) begin
        n_clamped <= n_next;
      end
      if (cmd.wr_mode) begin
        mode <= cfg_data[0];
      end

      if (cmd.grid_start) begin
        root    <= '0;
        col_cnt <= '0;
        row_cnt <= '0;
        idx_cnt <= '0;
      end else if (cmd.sqrt_step) begin
        if (trial_sq <= {1'b0, n_clamped}) begin
          root <= trial;
        end
      end

      if (cmd.grid_set) begin
        cols <= (root_sq == {1'b0, n_clamped}) ? root : DW'(root + 1'b1);
        rows <= ({1'b0, n_clamped} > (root_sq + (2*DW)'(root))) ? DW'(root + 1'b1) : root;
      end
      if (cmd.eff_set) begin
        eff <= mode ? n_clamped : CW'(grid_prod);
      end

      if (cmd.out_load) begin
        idx_cnt <= last ? '0 : IW'(idx_cnt + 1'b1);
        if (!mode) begin
          if (col_end) begin
            col_cnt <= '0;
            row_cnt <= last ? '0 : DW'(row_cnt + 1'b1);
          end else begin
            col_cnt <= DW'(col_cnt + 1'b1);
          end
        end
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_data.sample_u        <= quot_u;
      sample_data.sample_v        <= mode ? '0 : quot_v;
      sample_data.sample_index    <= idx_cnt;
      sample_data.effective_count <= eff;
      sample_data.pass_last       <= last;
    end
  end

  jgsg_div u_div_u (
    .clk     (clk),
    .load    (cmd.div_load),
    .step    (cmd.div_step),
    .pos     (pos_u),
    .frac    (rand_data.rand_u),
    .divisor (dvs_u),
    .quot    (quot_u)
  );

  jgsg_div u_div_v (
    .clk     (clk),
    .load    (cmd.div_load),
    .step    (cmd.div_step),
    .pos     (IW'(row_cnt)),
    .frac    (rand_data.rand_v),
    .divisor (CW'(rows)),
    .quot    (quot_v)
  );

endmodule

`default_nettype wire

>>> design/jittered_grid_sample_generator_unit.sv
// top level of the jittered grid sample generator: jgsg_ctrl + jgsg_datapath
// depends on jgsg_pkg and jittered_grid_sample_generator_unit_assert.svh
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   rand    | rand_valid/rand_stall | jgsg_pkg::in_item_t (rand_u, rand_v)
//   sample  | sample_valid/_stall   | jgsg_pkg::out_item_t (u, v, index, ...)
//   cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// per item: transfer, 16 steps of the two radix-2 divider lanes (u and v in
// parallel), then a result register load once the output is free; no new
// item is taken before that load, but one is taken while a result still
// waits on a stalled output. a config write runs the 7-step integer root
// search, then grid setup (ST_GRID, ST_EFF), with rand stalled. synchronous reset.
`timescale 1ns / 1ps
`default_nettype none

`include "jittered_grid_sample_generator_unit_assert.svh"

module jittered_grid_sample_generator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rand_valid,
  output logic                                rand_stall,
  input  wire jgsg_pkg::in_item_t             rand_data,
  output logic                                sample_valid,
  input  wire logic                           sample_stall,
  output jgsg_pkg::out_item_t                 sample_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [jgsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [jgsg_pkg::COUNT_W-1:0]   cfg_data
);

  jgsg_pkg::ctrl_cmd_t cmd;
  logic                at_pass_end;

  jgsg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .rand_valid   (rand_valid),
    .rand_stall   (rand_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cmd          (cmd)
  );

  jgsg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_data    (cfg_data),
    .rand_data   (rand_data),
    .sample_data (sample_data)
  );

  assign at_pass_end = (({1'b0, sample_data.sample_index} + 13'd1) ==
                        sample_data.effective_count);

  `JGSG_ASSERT_SAME(a_cfg_excl, clk, rst, cfg_valid && cfg_ready, !(rand_valid && !rand_stall))
  `JGSG_ASSERT_NEXT(a_busy_after_take, clk, rst, rand_valid && !rand_stall, rand_stall && !cfg_ready)
  `JGSG_ASSERT_SAME(a_last_at_end, clk, rst, sample_valid, sample_data.pass_last == at_pass_end)

endmodule

`default_nettype wire
